// ----- rtl/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// Sensor compensation package
// Shared beat types, register indexes and integer helpers for the
// temperature, pressure and humidity compensation pipeline.
// ----------------------------------------------------------------------------
package stc_pkg;

  // Width of the pipelined pressure divider.
  localparam int unsigned DivW = 32;

  // Configuration register indexes.
  localparam logic [2:0] REG_TEMP_CAL    = 3'd0;
  localparam logic [2:0] REG_PRESS_CAL_A = 3'd1;
  localparam logic [2:0] REG_PRESS_CAL_B = 3'd2;
  localparam logic [2:0] REG_PRESS_CAL_C = 3'd3;
  localparam logic [2:0] REG_HUM_CAL_A   = 3'd4;
  localparam logic [2:0] REG_HUM_CAL_B   = 3'd5;

  // Input beat: one raw sensor frame.
  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [31:0]        press_pa;
    logic [16:0]        hum_q10;
    logic signed [31:0] fine_temp;
    logic               press_fault;
  } out_t;

  // Side data that rides along with each divider beat.
  typedef struct packed {
    logic signed [14:0] temp;
    logic signed [31:0] tf;
    logic [16:0]        hum;
    logic               fault;
    logic               dbl;
  } side_t;

  // Low 32 bits of a signed product (wrapping multiply).
  function automatic logic signed [31:0] mul32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  // Division by 2**n that truncates toward zero.
  function automatic logic signed [31:0] tdiv(input logic signed [31:0] a,
                                              input logic [4:0] n);
    logic signed [31:0] bias;
    bias = a[31] ? ((32'sd1 <<< n) - 32'sd1) : 32'sd0;
    return (a + bias) >>> n;
  endfunction

endpackage

// ----- rtl/stc_udiv.sv -----
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, with side data carried
// alongside each beat. A new beat can enter every cycle.
// ----------------------------------------------------------------------------
module stc_udiv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [stc_pkg::DivW-1:0]   dividend_i,
  input  logic [stc_pkg::DivW-1:0]   divisor_i,
  input  stc_pkg::side_t             side_i,
  output logic                       valid_o,
  output logic [stc_pkg::DivW-1:0]   quotient_o,
  output stc_pkg::side_t             side_o
);

  localparam int unsigned W = stc_pkg::DivW;

  logic [W-1:0]   rem_q [W];
  logic [W-1:0]   dq_q  [W];
  logic [W-1:0]   den_q [W];
  stc_pkg::side_t side_q [W];
  logic [W-1:0]   vld_q;

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W-1:0]   rin;
    logic [W-1:0]   din;
    logic [W-1:0]   nin;
    stc_pkg::side_t sin;
    logic           vin;
    logic [W:0]     trial;

    // Stage inputs: ports for the first stage, previous stage otherwise.
    if (k == 0) begin : g_first
      assign rin = '0;
      assign din = dividend_i;
      assign nin = divisor_i;
      assign sin = side_i;
      assign vin = valid_i;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign din = dq_q[k-1];
      assign nin = den_q[k-1];
      assign sin = side_q[k-1];
      assign vin = vld_q[k-1];
    end

    // Trial subtract of the divisor from the shifted partial remainder.
    assign trial = {rin, din[W-1]} - {1'b0, nin};

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= trial[W] ? {rin[W-2:0], din[W-1]} : trial[W-1:0];
      dq_q[k]   <= {din[W-2:0], ~trial[W]};
      den_q[k]  <= nin;
      side_q[k] <= sin;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vin;
      end
    end
  end

  assign valid_o    = vld_q[W-1];
  assign quotient_o = dq_q[W-1];
  assign side_o     = side_q[W-1];

endmodule

// ----- rtl/sensor_thp_compensation.sv -----
// ----------------------------------------------------------------------------
// Sensor temperature, pressure and humidity compensation
// Fixed-point calibration of one raw sensor frame per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start_i with a raw frame on in_i; the beat is taken at that edge.
//   busy_o stays low, so a new frame may be given in every cycle.
//   Each result appears on out_o for one cycle with valid_o high, in input
//   order; the receiver cannot stall.
//   The pipeline holds 13 arithmetic stages (temperature, then the pressure
//   and humidity chains side by side), the 32-stage pressure divider and
//   3 stages of pressure correction. Throughput is one frame per cycle.
//   Calibration words are written through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   while no frame is in flight; writes to unknown indexes are ignored.
//   Reset clears all calibration words and empties the pipeline.
//   A zero pressure denominator gives press_pa of zero with press_fault set.
// ----------------------------------------------------------------------------
module sensor_thp_compensation (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  stc_pkg::in_t   in_i,
  output logic           valid_o,
  output stc_pkg::out_t  out_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [63:0]    cfg_wdata_i
);

  typedef logic signed [31:0] s32_t;

  // Calibration registers.
  logic [47:0] temp_cal_q;
  logic [63:0] press_cal_a_q;
  logic [63:0] press_cal_b_q;
  logic [15:0] press_cal_c_q;
  logic [31:0] hum_cal_a_q;
  logic [39:0] hum_cal_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q    <= '0;
      press_cal_a_q <= '0;
      press_cal_b_q <= '0;
      press_cal_c_q <= '0;
      hum_cal_a_q   <= '0;
      hum_cal_b_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        stc_pkg::REG_TEMP_CAL:    temp_cal_q    <= cfg_wdata_i[47:0];
        stc_pkg::REG_PRESS_CAL_A: press_cal_a_q <= cfg_wdata_i;
        stc_pkg::REG_PRESS_CAL_B: press_cal_b_q <= cfg_wdata_i;
        stc_pkg::REG_PRESS_CAL_C: press_cal_c_q <= cfg_wdata_i[15:0];
        stc_pkg::REG_HUM_CAL_A:   hum_cal_a_q   <= cfg_wdata_i[31:0];
        stc_pkg::REG_HUM_CAL_B:   hum_cal_b_q   <= cfg_wdata_i[39:0];
        default: ;
      endcase
    end
  end

  // Coefficients, extended to 32 bits.
  s32_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
  assign t1 = s32_t'({16'd0, temp_cal_q[15:0]});
  assign t2 = s32_t'(signed'(temp_cal_q[31:16]));
  assign t3 = s32_t'(signed'(temp_cal_q[47:32]));
  assign p1 = s32_t'({16'd0, press_cal_a_q[15:0]});
  assign p2 = s32_t'(signed'(press_cal_a_q[31:16]));
  assign p3 = s32_t'(signed'(press_cal_a_q[47:32]));
  assign p4 = s32_t'(signed'(press_cal_a_q[63:48]));
  assign p5 = s32_t'(signed'(press_cal_b_q[15:0]));
  assign p6 = s32_t'(signed'(press_cal_b_q[31:16]));
  assign p7 = s32_t'(signed'(press_cal_b_q[47:32]));
  assign p8 = s32_t'(signed'(press_cal_b_q[63:48]));
  assign p9 = s32_t'(signed'(press_cal_c_q));
  assign h1 = s32_t'({24'd0, hum_cal_a_q[7:0]});
  assign h2 = s32_t'(signed'(hum_cal_a_q[23:8]));
  assign h3 = s32_t'({24'd0, hum_cal_a_q[31:24]});
  assign h4 = s32_t'(signed'(hum_cal_b_q[15:0]));
  assign h5 = s32_t'(signed'(hum_cal_b_q[31:16]));
  assign h6 = s32_t'(signed'(hum_cal_b_q[39:32]));

  assign busy_o = 1'b0;

  // Valid bits of the front stages, one per stage.
  logic [12:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[11:0], start_i};
    end
  end

  // Stage 1: temperature differences.
  s32_t        ta1_q, tb1_q;
  logic [19:0] adcp1_q;
  logic [15:0] adch1_q;
  always_ff @(posedge clk_i) begin
    ta1_q   <= s32_t'({15'd0, in_i.raw_temp[19:3]}) - (t1 <<< 1);
    tb1_q   <= s32_t'({16'd0, in_i.raw_temp[19:4]}) - t1;
    adcp1_q <= in_i.raw_press;
    adch1_q <= in_i.raw_hum;
  end

  // Stage 2: temperature products.
  s32_t        tma2_q, tmb2_q;
  logic [19:0] adcp2_q;
  logic [15:0] adch2_q;
  always_ff @(posedge clk_i) begin
    tma2_q  <= stc_pkg::mul32(ta1_q, t2);
    tmb2_q  <= stc_pkg::mul32(tb1_q, tb1_q);
    adcp2_q <= adcp1_q;
    adch2_q <= adch1_q;
  end

  // Stage 3: scale and apply the quadratic coefficient.
  s32_t        ta3_q, tmc3_q;
  logic [19:0] adcp3_q;
  logic [15:0] adch3_q;
  always_ff @(posedge clk_i) begin
    ta3_q   <= stc_pkg::tdiv(tma2_q, 5'd11);
    tmc3_q  <= stc_pkg::mul32(stc_pkg::tdiv(tmb2_q, 5'd12), t3);
    adcp3_q <= adcp2_q;
    adch3_q <= adch2_q;
  end

  // Stage 4: fine temperature.
  s32_t        tf4_q;
  logic [19:0] adcp4_q;
  logic [15:0] adch4_q;
  always_ff @(posedge clk_i) begin
    tf4_q   <= ta3_q + stc_pkg::tdiv(tmc3_q, 5'd14);
    adcp4_q <= adcp3_q;
    adch4_q <= adch3_q;
  end

  // Stage 5: clamped temperature and the first pressure / humidity terms.
  s32_t               tscl5, pa5;
  logic signed [14:0] temp5;
  assign tscl5 = stc_pkg::tdiv(stc_pkg::mul32(tf4_q, 32'sd5) + 32'sd128, 5'd8);
  assign pa5   = (tf4_q >>> 1) - 32'sd64000;

  always_comb begin
    if (tscl5 < -32'sd4000) begin
      temp5 = -15'sd4000;
    end else if (tscl5 > 32'sd8500) begin
      temp5 = 15'sd8500;
    end else begin
      temp5 = tscl5[14:0];
    end
  end

  s32_t               tf5_q, pa5_q, pc5_q, ha5_q;
  logic signed [14:0] temp5_q;
  logic [19:0]        adcp5_q;
  logic [15:0]        adch5_q;
  always_ff @(posedge clk_i) begin
    tf5_q   <= tf4_q;
    temp5_q <= temp5;
    pa5_q   <= pa5;
    pc5_q   <= stc_pkg::mul32(pa5 >>> 2, pa5 >>> 2);
    ha5_q   <= tf4_q - 32'sd76800;
    adcp5_q <= adcp4_q;
    adch5_q <= adch4_q;
  end

  // Values that travel unchanged down the later front stages.
  typedef struct packed {
    logic signed [14:0] temp;
    logic signed [31:0] tf;
  } carry_t;

  carry_t c5;
  assign c5 = '{temp: temp5_q, tf: tf5_q};

  // Stage 6: pressure and humidity products.
  carry_t      c6_q;
  s32_t        pm1_6_q, pm2_6_q, pm3_6_q, pm4_6_q, hd6_q, hm6_6_q, hm3_6_q;
  logic [15:0] adch6_q;
  logic [19:0] adcp6_q;
  always_ff @(posedge clk_i) begin
    c6_q    <= c5;
    pm1_6_q <= stc_pkg::mul32(pc5_q >>> 11, p6);
    pm2_6_q <= stc_pkg::mul32(pa5_q, p5);
    pm3_6_q <= stc_pkg::mul32(p3, pc5_q >>> 13);
    pm4_6_q <= stc_pkg::mul32(p2, pa5_q);
    hd6_q   <= stc_pkg::mul32(h5, ha5_q);
    hm6_6_q <= stc_pkg::mul32(ha5_q, h6);
    hm3_6_q <= stc_pkg::mul32(ha5_q, h3);
    adch6_q <= adch5_q;
    adcp6_q <= adcp5_q;
  end

  // Stage 7: pressure sums and first humidity scaling.
  s32_t pb7, pasum7, hsum7;
  assign pb7    = ((pm1_6_q + (pm2_6_q <<< 1)) >>> 2) + (p4 <<< 16);
  assign pasum7 = ((pm3_6_q >>> 3) + (pm4_6_q >>> 1)) >>> 18;
  assign hsum7  = s32_t'({2'd0, adch6_q, 14'd0}) - s32_t'({h4[11:0], 20'd0})
                  - hd6_q + 32'sd16384;

  carry_t      c7_q;
  s32_t        pb7_q, px7_q, he7_q, hb7_q, hc7_q;
  logic [19:0] adcp7_q;
  always_ff @(posedge clk_i) begin
    c7_q    <= c6_q;
    pb7_q   <= pb7;
    px7_q   <= 32'sd32768 + pasum7;
    he7_q   <= stc_pkg::tdiv(hsum7, 5'd15);
    hb7_q   <= stc_pkg::tdiv(hm6_6_q, 5'd10);
    hc7_q   <= stc_pkg::tdiv(hm3_6_q, 5'd11) + 32'sd32768;
    adcp7_q <= adcp6_q;
  end

  // Pressure numerator, denominator and fault as one group.
  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        fault;
  } pdiv_t;

  // Stage 8: pressure numerator and denominator, and a humidity product.
  s32_t  pden8, pnum8;
  assign pden8 = stc_pkg::mul32(px7_q, p1) >>> 15;
  assign pnum8 = stc_pkg::mul32((32'sd1048576 - s32_t'({12'd0, adcp7_q}))
                                - (pb7_q >>> 12), 32'sd3125);

  carry_t c8_q;
  pdiv_t  pd8_q;
  s32_t   he8_q, hm8_q;
  always_ff @(posedge clk_i) begin
    c8_q  <= c7_q;
    pd8_q <= '{num: pnum8, den: pden8, fault: (pden8 == 32'sd0)};
    he8_q <= he7_q;
    hm8_q <= stc_pkg::mul32(hb7_q, hc7_q);
  end

  // Stage 9: humidity offset term times H2.
  carry_t c9_q;
  pdiv_t  pd9_q;
  s32_t   he9_q, hmd9_q;
  always_ff @(posedge clk_i) begin
    c9_q   <= c8_q;
    pd9_q  <= pd8_q;
    he9_q  <= he8_q;
    hmd9_q <= stc_pkg::mul32(stc_pkg::tdiv(hm8_q, 5'd10) + 32'sd2097152, h2);
  end

  // Stage 10: combined humidity product.
  carry_t c10_q;
  pdiv_t  pd10_q;
  s32_t   hc10_q;
  always_ff @(posedge clk_i) begin
    c10_q  <= c9_q;
    pd10_q <= pd9_q;
    hc10_q <= stc_pkg::mul32(he9_q, stc_pkg::tdiv(hmd9_q + 32'sd8192, 5'd14));
  end

  // Stage 11: square of the scaled humidity product.
  s32_t  hq11;
  assign hq11 = stc_pkg::tdiv(hc10_q, 5'd15);

  carry_t c11_q;
  pdiv_t  pd11_q;
  s32_t   hc11_q, hsq11_q;
  always_ff @(posedge clk_i) begin
    c11_q   <= c10_q;
    pd11_q  <= pd10_q;
    hc11_q  <= hc10_q;
    hsq11_q <= stc_pkg::mul32(hq11, hq11);
  end

  // Stage 12: H1 correction product.
  carry_t c12_q;
  pdiv_t  pd12_q;
  s32_t   hc12_q, hmd12_q;
  always_ff @(posedge clk_i) begin
    c12_q   <= c11_q;
    pd12_q  <= pd11_q;
    hc12_q  <= hc11_q;
    hmd12_q <= stc_pkg::mul32(stc_pkg::tdiv(hsq11_q, 5'd7), h1);
  end

  // Stage 13: humidity clamp and scale.
  s32_t        he13, hcl13;
  logic [16:0] hum13;
  assign he13 = hc12_q - stc_pkg::tdiv(hmd12_q, 5'd4);

  always_comb begin
    if (he13 < 32'sd0) begin
      hcl13 = 32'sd0;
    end else if (he13 > 32'sd419430400) begin
      hcl13 = 32'sd419430400;
    end else begin
      hcl13 = he13;
    end
    hum13 = hcl13[28:12];
    if (hum13 > 17'd102400) begin
      hum13 = 17'd102400;
    end
  end

  carry_t      c13_q;
  pdiv_t       pd13_q;
  logic [16:0] hum13_q;
  always_ff @(posedge clk_i) begin
    c13_q   <= c12_q;
    pd13_q  <= pd12_q;
    hum13_q <= hum13;
  end

  // Divider: a numerator with its top bit clear is doubled before division,
  // otherwise the quotient is doubled afterwards.
  logic [31:0]    div_dvd;
  stc_pkg::side_t div_side_in, div_side;
  logic           div_vld;
  logic [31:0]    div_quo;

  assign div_dvd     = pd13_q.num[31] ? pd13_q.num : {pd13_q.num[30:0], 1'b0};
  assign div_side_in = '{temp: c13_q.temp, tf: c13_q.tf, hum: hum13_q,
                         fault: pd13_q.fault, dbl: pd13_q.num[31]};

  stc_udiv u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vld_q[12]),
    .dividend_i (div_dvd),
    .divisor_i  (pd13_q.den),
    .side_i     (div_side_in),
    .valid_o    (div_vld),
    .quotient_o (div_quo),
    .side_o     (div_side)
  );

  // Back stage A: raw pressure and its correction products.
  logic [31:0] pa_p;
  assign pa_p = div_side.dbl ? {div_quo[30:0], 1'b0} : div_quo;

  logic           va_q;
  stc_pkg::side_t sa_q;
  logic [31:0]    pa_q, psq_q;
  s32_t           pm8_q;
  always_ff @(posedge clk_i) begin
    sa_q  <= div_side;
    pa_q  <= pa_p;
    psq_q <= stc_pkg::mul32(s32_t'({3'd0, pa_p[31:3]}), s32_t'({3'd0, pa_p[31:3]}));
    pm8_q <= stc_pkg::mul32(s32_t'({2'd0, pa_p[31:2]}), p8);
  end

  // Back stage B: P9 product.
  logic           vb_q;
  stc_pkg::side_t sb_q;
  logic [31:0]    pb_q;
  s32_t           pm9_q, pb13_q;
  always_ff @(posedge clk_i) begin
    sb_q   <= sa_q;
    pb_q   <= pa_q;
    pm9_q  <= stc_pkg::mul32(p9, s32_t'({13'd0, psq_q[31:13]}));
    pb13_q <= pm8_q >>> 13;
  end

  // Back stage C: final pressure into the output register.
  s32_t        pcorr;
  logic [31:0] pfin;
  assign pcorr = ((pm9_q >>> 12) + pb13_q + p7) >>> 4;
  assign pfin  = sb_q.fault ? 32'd0 : (pb_q + pcorr);

  stc_pkg::out_t out_q;
  logic          valid_q;
  always_ff @(posedge clk_i) begin
    out_q <= '{temp_centi: sb_q.temp, press_pa: pfin, hum_q10: sb_q.hum,
               fine_temp: sb_q.tf, press_fault: sb_q.fault};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      va_q    <= div_vld;
      vb_q    <= va_q;
      valid_q <= vb_q;
    end
  end

  assign valid_o = valid_q;
  assign out_o   = out_q;

endmodule

// ----- dv/sensor_thp_compensation_tb.sv -----
// ----------------------------------------------------------------------------
// Sensor compensation testbench
// Drives raw temperature, pressure and humidity frames into the compensation
// pipeline under several calibration sets. A directed table comes first. It
// covers reset calibration, field extremes and a zero pressure denominator.
// Random frames follow, with random gaps and back-to-back bursts. Each result
// beat is compared field by field with an integer predictor or a typed-in row.
// ----------------------------------------------------------------------------
module sensor_thp_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PipeLatency = 48;
  localparam int unsigned SettleCycles = PipeLatency + 12;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandPhases = 8;
  localparam int unsigned FramesPerPhase = 138;

  // One row of the directed table.
  typedef struct {
    stc_pkg::in_t  frame;
    bit            known;
    stc_pkg::out_t want;
  } frame_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start_i = 1'b0;
  logic          busy_o;
  stc_pkg::in_t  in_i = '0;
  logic          valid_o;
  stc_pkg::out_t out_o;
  logic          cfg_we_i = 1'b0;
  logic [2:0]    cfg_idx_i = stc_pkg::REG_TEMP_CAL;
  logic [63:0]   cfg_wdata_i = '0;

  // Typed-in expectation that rides along with a directed beat.
  bit            frame_known = 1'b0;
  stc_pkg::out_t frame_want = '0;

  // Calibration copy kept by the predictor.
  logic [47:0] cal_temp;
  logic [63:0] cal_press_a;
  logic [63:0] cal_press_b;
  logic [15:0] cal_press_c;
  logic [31:0] cal_hum_a;
  logic [39:0] cal_hum_b;

  stc_pkg::out_t pending_results[$];
  int unsigned   cycle_count = 0;
  bit            failed = 1'b0;

  sensor_thp_compensation DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .valid_o    (valid_o),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Integer compensation of one frame with the current calibration.
  function automatic stc_pkg::out_t compensate_frame(input stc_pkg::in_t f);
    int t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    int h1, h2, h3, h4, h5, h6;
    int adc_t, adc_p, adc_h;
    int a, b, c, d, e, tf, temp;
    logic [31:0] pu, den, sq;
    stc_pkg::out_t r;
    adc_t = f.raw_temp;
    adc_p = f.raw_press;
    adc_h = f.raw_hum;
    t1 = cal_temp[15:0];
    t2 = $signed(cal_temp[31:16]);
    t3 = $signed(cal_temp[47:32]);
    p1 = cal_press_a[15:0];
    p2 = $signed(cal_press_a[31:16]);
    p3 = $signed(cal_press_a[47:32]);
    p4 = $signed(cal_press_a[63:48]);
    p5 = $signed(cal_press_b[15:0]);
    p6 = $signed(cal_press_b[31:16]);
    p7 = $signed(cal_press_b[47:32]);
    p8 = $signed(cal_press_b[63:48]);
    p9 = $signed(cal_press_c);
    h1 = cal_hum_a[7:0];
    h2 = $signed(cal_hum_a[23:8]);
    h3 = cal_hum_a[31:24];
    h4 = $signed(cal_hum_b[15:0]);
    h5 = $signed(cal_hum_b[31:16]);
    h6 = $signed(cal_hum_b[39:32]);
    r = '0;

    // Fine temperature and clamped temperature.
    a = adc_t / 8 - t1 * 2;
    a = (a * t2) / 2048;
    b = adc_t / 16 - t1;
    b = (((b * b) / 4096) * t3) / 16384;
    tf = a + b;
    temp = (tf * 5 + 128) / 256;
    if (temp < -4000) temp = -4000;
    else if (temp > 8500) temp = 8500;

    // Pressure, with the zero denominator flagged.
    a = (tf >>> 1) - 64000;
    c = (a >>> 2) * (a >>> 2);
    b = (c >>> 11) * p6;
    b = b + ((a * p5) <<< 1);
    b = (b >>> 2) + (p4 <<< 16);
    a = (((p3 * (c >>> 13)) >>> 3) + ((p2 * a) >>> 1)) >>> 18;
    a = ((32768 + a) * p1) >>> 15;
    if (a == 0) begin
      pu = '0;
      r.press_fault = 1'b1;
    end else begin
      den = a;
      pu = 32'(1048576 - adc_p) - 32'(b >>> 12);
      pu = pu * 32'd3125;
      if (pu < 32'h8000_0000) pu = (pu << 1) / den;
      else pu = (pu / den) * 32'd2;
      sq = (pu >> 3) * (pu >> 3);
      a = (p9 * int'(sq >> 13)) >>> 12;
      b = (int'(pu >> 2) * p8) >>> 13;
      pu = pu + 32'((a + b + p7) >>> 4);
    end

    // Humidity in Q22.10, clamped.
    a = tf - 76800;
    b = adc_h * 16384;
    c = h4 * 1048576;
    d = h5 * a;
    e = (b - c - d + 16384) / 32768;
    b = (a * h6) / 1024;
    c = (a * h3) / 2048;
    d = (b * (c + 32768)) / 1024 + 2097152;
    b = (d * h2 + 8192) / 16384;
    c = e * b;
    d = ((c / 32768) * (c / 32768)) / 128;
    e = c - (d * h1) / 16;
    if (e < 0) e = 0;
    if (e > 419430400) e = 419430400;
    e = e / 4096;
    if (e > 102400) e = 102400;

    r.temp_centi = temp[14:0];
    r.press_pa = pu;
    r.hum_q10 = e[16:0];
    r.fine_temp = tf;
    return r;
  endfunction

  // Track calibration writes, queue expectations and check result beats.
  always @(posedge clk_i) begin
    stc_pkg::out_t want;
    if (!rst_ni) begin
      cal_temp <= '0;
      cal_press_a <= '0;
      cal_press_b <= '0;
      cal_press_c <= '0;
      cal_hum_a <= '0;
      cal_hum_b <= '0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("FAIL sensor_thp_compensation");
        $finish;
      end
      if (start_i && !busy_o) begin
        want = frame_known ? frame_want : compensate_frame(in_i);
        pending_results.push_back(want);
      end
      if (valid_o) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, out_o);
          failed = 1'b1;
        end else begin
          want = pending_results.pop_front();
          if (out_o.temp_centi !== want.temp_centi) begin
            $display("%0t: temp_centi expected %0d got %0d", $time,
                     want.temp_centi, out_o.temp_centi);
            failed = 1'b1;
          end
          if (out_o.press_pa !== want.press_pa) begin
            $display("%0t: press_pa expected %0d got %0d", $time,
                     want.press_pa, out_o.press_pa);
            failed = 1'b1;
          end
          if (out_o.hum_q10 !== want.hum_q10) begin
            $display("%0t: hum_q10 expected %0d got %0d", $time,
                     want.hum_q10, out_o.hum_q10);
            failed = 1'b1;
          end
          if (out_o.fine_temp !== want.fine_temp) begin
            $display("%0t: fine_temp expected %0d got %0d", $time,
                     want.fine_temp, out_o.fine_temp);
            failed = 1'b1;
          end
          if (out_o.press_fault !== want.press_fault) begin
            $display("%0t: press_fault expected %0b got %0b", $time,
                     want.press_fault, out_o.press_fault);
            failed = 1'b1;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          stc_pkg::REG_TEMP_CAL:    cal_temp <= cfg_wdata_i[47:0];
          stc_pkg::REG_PRESS_CAL_A: cal_press_a <= cfg_wdata_i;
          stc_pkg::REG_PRESS_CAL_B: cal_press_b <= cfg_wdata_i;
          stc_pkg::REG_PRESS_CAL_C: cal_press_c <= cfg_wdata_i[15:0];
          stc_pkg::REG_HUM_CAL_A:   cal_hum_a <= cfg_wdata_i[31:0];
          stc_pkg::REG_HUM_CAL_B:   cal_hum_b <= cfg_wdata_i[39:0];
          default: ;
        endcase
      end
    end
  end

  // Offer one frame beat after an idle gap; returns at its accepting edge.
  task automatic send_frame(input stc_pkg::in_t f, input bit known,
                            input stc_pkg::out_t want, input int unsigned gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i <= f;
    frame_known <= known;
    frame_want <= want;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Stop offering frames and let the pipeline empty.
  task automatic drain_pipeline();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all six calibration words plus the two unused indexes.
  task automatic load_calibration(input logic [63:0] w0, input logic [63:0] w1,
                                  input logic [63:0] w2, input logic [63:0] w3,
                                  input logic [63:0] w4, input logic [63:0] w5);
    logic [63:0] words[6];
    words = '{w0, w1, w2, w3, w4, w5};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 3'(i);
      cfg_wdata_i <= words[i];
      @(posedge clk_i);
    end
    cfg_idx_i <= 3'(stc_pkg::REG_HUM_CAL_B + 1);
    cfg_wdata_i <= {$urandom, $urandom};
    @(posedge clk_i);
    cfg_idx_i <= 3'(stc_pkg::REG_HUM_CAL_B + 2);
    cfg_wdata_i <= {$urandom, $urandom};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Typical calibration of a production part.
  task automatic load_typical();
    load_calibration({16'hFC18, 16'd26435, 16'd27504},
                     {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                     {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                     64'd6000,
                     {8'd0, 16'd362, 8'd75},
                     {8'd30, 16'd50, 16'd313});
  endtask

  // Raw frame, either anywhere in range or near typical readings.
  function automatic stc_pkg::in_t random_frame();
    stc_pkg::in_t f;
    if ($urandom_range(0, 1) == 0) begin
      f.raw_temp = 20'($urandom);
      f.raw_press = 20'($urandom);
      f.raw_hum = 16'($urandom);
    end else begin
      f.raw_temp = 20'(519888 + $urandom_range(0, 131071) - 65536);
      f.raw_press = 20'(415148 + $urandom_range(0, 131071) - 65536);
      f.raw_hum = 16'(27000 + $urandom_range(0, 16383) - 8192);
    end
    return f;
  endfunction

  // Stimulus.
  initial begin
    frame_row_t    reset_rows[4];
    frame_row_t    cal_rows[7];
    stc_pkg::out_t reset_result;
    bit            bursty;
    int unsigned   gap;

    // With all-zero calibration: fine temperature 0, no humidity, and
    // the pressure denominator is zero.
    reset_result = '0;
    reset_result.press_fault = 1'b1;
    reset_rows[0] = '{'{20'd0, 20'd0, 16'd0}, 1'b1, reset_result};
    reset_rows[1] = '{'{20'hFFFFF, 20'hFFFFF, 16'hFFFF}, 1'b1, reset_result};
    reset_rows[2] = '{'{20'h80000, 20'h7FFFF, 16'h8000}, 1'b1, reset_result};
    reset_rows[3] = '{'{20'h55555, 20'hAAAAA, 16'h5A5A}, 1'b1, reset_result};
    cal_rows[0] = '{'{20'd519888, 20'd415148, 16'd27000}, 1'b0, '0};
    cal_rows[1] = '{'{20'd0, 20'd0, 16'd0}, 1'b0, '0};
    cal_rows[2] = '{'{20'hFFFFF, 20'hFFFFF, 16'hFFFF}, 1'b0, '0};
    cal_rows[3] = '{'{20'd0, 20'hFFFFF, 16'hFFFF}, 1'b0, '0};
    cal_rows[4] = '{'{20'hFFFFF, 20'd0, 16'd0}, 1'b0, '0};
    cal_rows[5] = '{'{20'd400000, 20'd300000, 16'd40000}, 1'b0, '0};
    cal_rows[6] = '{'{20'd600000, 20'd500000, 16'd12000}, 1'b0, '0};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset calibration, then typical, all ones and sign extremes.
    foreach (reset_rows[i])
      send_frame(reset_rows[i].frame, 1'b1, reset_rows[i].want, i % 2);
    drain_pipeline();
    load_typical();
    foreach (cal_rows[i]) send_frame(cal_rows[i].frame, 1'b0, '0, 0);
    drain_pipeline();
    load_calibration('1, '1, '1, '1, '1, '1);
    foreach (cal_rows[i]) send_frame(cal_rows[i].frame, 1'b0, '0, 1);
    drain_pipeline();
    load_calibration({16'h8000, 16'h8000, 16'hFFFF}, {4{16'h8000}},
                     {4{16'h8000}}, 64'h8000, {8'hFF, 16'h8000, 8'hFF},
                     {8'h80, 16'h8000, 16'h8000});
    foreach (cal_rows[i]) send_frame(cal_rows[i].frame, 1'b0, '0, 2);
    drain_pipeline();

    // Random phases: typical, random and all-zero calibration, bursty or gapped.
    for (int ph = 0; ph < RandPhases; ph++) begin
      if (ph % 3 == 0) load_typical();
      else if (ph == RandPhases - 1)
        load_calibration('0, '0, '0, '0, '0, '0);
      else
        load_calibration({$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, {$urandom, $urandom});
      bursty = (ph % 2 == 1);
      for (int n = 0; n < FramesPerPhase; n++) begin
        gap = (bursty || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        send_frame(random_frame(), 1'b0, '0, gap);
      end
      drain_pipeline();
    end

    if (!failed) begin
      $display("PASS sensor_thp_compensation");
    end else begin
      $display("FAIL sensor_thp_compensation");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/stc_pkg.sv
rtl/stc_udiv.sv
rtl/sensor_thp_compensation.sv
dv/sensor_thp_compensation_tb.sv
